/* hw/rtl/hcd_pkg.sv */
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared constants and types for the sync-header packet deframer.
// ----------------------------------------------------------------------------
package hcd_pkg;

  localparam int PACKET_BYTES = 12;
  localparam int BODY_BYTES   = PACKET_BYTES - 3;
  localparam int FILL_W       = $clog2(PACKET_BYTES + 1);

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  localparam logic KIND_GOOD = 1'b0;
  localparam logic KIND_BAD  = 1'b1;

  typedef logic [PACKET_BYTES-1:0][7:0] window_t;
  typedef logic [FILL_W-1:0]            fill_t;

  typedef struct packed {
    logic                       kind;
    logic [BODY_BYTES-1:0][7:0] body;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

/* hw/rtl/hcd_ifs.sv */
// ----------------------------------------------------------------------------
// hcd channel interfaces
// Byte input channel and decoded result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface hcd_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic        [7:0]  seq_number;
  logic signed [7:0]  class_code;
  logic        [7:0]  confidence;
  logic signed [15:0] x_coord;
  logic signed [15:0] y_coord;
  logic        [15:0] time_ms;

  modport source (
    output valid, output result_kind, output seq_number, output class_code,
    output confidence, output x_coord, output y_coord, output time_ms,
    input ready
  );
  modport sink (
    input valid, input result_kind, input seq_number, input class_code,
    input confidence, input x_coord, input y_coord, input time_ms,
    output ready
  );
endinterface

/* hw/rtl/hcd_front.sv */
// ----------------------------------------------------------------------------
// hcd_front
// Byte window with fill count; checks header and checksum when full.
// ----------------------------------------------------------------------------
module hcd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  hcd_pkg::q_stat_t q_stat,
  output logic             push,
  output hcd_pkg::cmd_t    push_cmd
);

  hcd_pkg::window_t win_r, win_nxt;
  hcd_pkg::fill_t   fill_r, fill_nxt;
  hcd_pkg::window_t w;
  hcd_pkg::fill_t   sync_pos;
  hcd_pkg::fill_t   drop;
  logic [7:0]       sum;
  logic             accept;
  logic             full_now;
  logic             hdr_ok;
  logic             sum_ok;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign full_now = fill_r == hcd_pkg::FILL_W'(hcd_pkg::PACKET_BYTES - 1);

  always_comb begin
    w = win_r;
    for (int i = 0; i < hcd_pkg::PACKET_BYTES; i++) begin
      if (fill_r == hcd_pkg::FILL_W'(i)) begin
        w[i] = in_byte;
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < hcd_pkg::PACKET_BYTES - 1; i++) begin
      sum = sum + w[i];
    end
    sync_pos = hcd_pkg::FILL_W'(hcd_pkg::PACKET_BYTES);
    for (int i = hcd_pkg::PACKET_BYTES - 1; i >= 1; i--) begin
      if (w[i] == hcd_pkg::SYNC_FIRST) begin
        sync_pos = hcd_pkg::FILL_W'(i);
      end
    end
  end

  assign hdr_ok = (w[0] == hcd_pkg::SYNC_FIRST) && (w[1] == hcd_pkg::SYNC_SECOND);
  assign sum_ok = sum == w[hcd_pkg::PACKET_BYTES-1];

  always_comb begin
    if (!hdr_ok) begin
      drop = sync_pos;
    end else if (!sum_ok) begin
      drop = hcd_pkg::FILL_W'(1);
    end else begin
      drop = hcd_pkg::FILL_W'(hcd_pkg::PACKET_BYTES);
    end
  end

  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    if (accept) begin
      win_nxt = w;
      if (full_now) begin
        fill_nxt = hcd_pkg::FILL_W'(hcd_pkg::PACKET_BYTES) - drop;
        for (int i = 0; i < hcd_pkg::PACKET_BYTES; i++) begin
          for (int k = 1; k < hcd_pkg::PACKET_BYTES; k++) begin
            if ((i + k < hcd_pkg::PACKET_BYTES) && (drop == hcd_pkg::FILL_W'(k))) begin
              win_nxt[i] = w[i+k];
            end
          end
        end
      end else begin
        fill_nxt = fill_r + hcd_pkg::FILL_W'(1);
      end
    end
  end

  assign push = accept && full_now && hdr_ok;

  always_comb begin
    push_cmd.kind = sum_ok ? hcd_pkg::KIND_GOOD : hcd_pkg::KIND_BAD;
    for (int k = 0; k < hcd_pkg::BODY_BYTES; k++) begin
      push_cmd.body[k] = w[k+2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

/* hw/rtl/hcd_queue.sv */
// ----------------------------------------------------------------------------
// hcd_queue
// Two-entry queue of classified packets between the front and back parts.
// ----------------------------------------------------------------------------
module hcd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hcd_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output hcd_pkg::cmd_t    head_cmd,
  output hcd_pkg::q_stat_t q_stat
);

  hcd_pkg::cmd_t mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign q_stat.full      = count_r == 2'd2;
  assign q_stat.not_empty = count_r != 2'd0;
  assign do_push          = push && !q_stat.full;
  assign do_pop           = pop && q_stat.not_empty;
  assign head_cmd         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* hw/rtl/hcd_back.sv */
// ----------------------------------------------------------------------------
// hcd_back
// Decodes queued packets into result fields held in the output register.
// ----------------------------------------------------------------------------
module hcd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  hcd_pkg::cmd_t    head_cmd,
  input  hcd_pkg::q_stat_t q_stat,
  output logic             pop,
  hcd_out_if.source        out_ch
);

  logic               valid_r, valid_nxt;
  logic               kind_r;
  logic        [7:0]  seq_r;
  logic signed [7:0]  class_r;
  logic        [7:0]  conf_r;
  logic signed [15:0] x_r;
  logic signed [15:0] y_r;
  logic        [15:0] t_r;
  logic               load;
  logic               good;

  assign load = q_stat.not_empty && (!valid_r || out_ch.ready);
  assign pop  = load;
  assign good = head_cmd.kind == hcd_pkg::KIND_GOOD;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // A failed checksum reports zeros in every field except the kind.
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= head_cmd.kind;
      seq_r   <= good ? head_cmd.body[0] : 8'd0;
      class_r <= good ? head_cmd.body[1] : 8'sd0;
      conf_r  <= good ? head_cmd.body[2] : 8'd0;
      x_r     <= good ? {head_cmd.body[4], head_cmd.body[3]} : 16'sd0;
      y_r     <= good ? {head_cmd.body[6], head_cmd.body[5]} : 16'sd0;
      t_r     <= good ? {head_cmd.body[8], head_cmd.body[7]} : 16'd0;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.result_kind = kind_r;
  assign out_ch.seq_number  = seq_r;
  assign out_ch.class_code  = class_r;
  assign out_ch.confidence  = conf_r;
  assign out_ch.x_coord     = x_r;
  assign out_ch.y_coord     = y_r;
  assign out_ch.time_ms     = t_r;

endmodule

/* hw/rtl/header_checksum_packet_deframer.sv */
// ----------------------------------------------------------------------------
// header_checksum_packet_deframer
// Finds AA 55 framed 12-byte packets in a byte stream, checks the additive
// checksum and reports decoded packets or checksum failures.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while in_ch.ready is high. A byte
// completing the 12-byte window is classified in that same cycle and written
// into a two-entry queue at the accepting edge; the result is then loaded into
// the output register when that register is empty or its result is taken,
// which raises out_ch.valid. in_ch.ready falls only while that queue is full,
// which happens when the result side stalls.
module header_checksum_packet_deframer (
  input logic       clk,
  input logic       rst_n,
  hcd_in_if.sink    in_ch,
  hcd_out_if.source out_ch
);

  hcd_pkg::q_stat_t q_stat;
  hcd_pkg::cmd_t    push_cmd;
  hcd_pkg::cmd_t    head_cmd;
  logic             push;
  logic             pop;

  hcd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.data_byte),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  hcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  hcd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_cmd (head_cmd),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

/* hw/rtl/hcd_checker.sv */
// ----------------------------------------------------------------------------
// hcd_checker
// Port-level checks for the packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
module hcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [7:0]  out_seq,
  input logic [7:0]  out_class,
  input logic [7:0]  out_conf,
  input logic [15:0] out_x,
  input logic [15:0] out_y,
  input logic [15:0] out_t
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == hcd_pkg::KIND_BAD) |->
      (out_seq == 8'd0) && (out_class == 8'd0) && (out_conf == 8'd0) &&
      (out_x == 16'd0) && (out_y == 16'd0) && (out_t == 16'd0))
    else $error("bad packet result carries nonzero fields");

  a_reset_out: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
    else $error("result present right after reset");

  a_reset_in: assert property (@(posedge clk) $rose(rst_n) |-> in_ready)
    else $error("input not ready right after reset");

endmodule

bind header_checksum_packet_deframer hcd_checker u_hcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.result_kind),
  .out_seq   (out_ch.seq_number),
  .out_class (out_ch.class_code),
  .out_conf  (out_ch.confidence),
  .out_x     (out_ch.x_coord),
  .out_y     (out_ch.y_coord),
  .out_t     (out_ch.time_ms)
);
